// File: sv/psd_pkg.sv
`default_nettype none
package psd_pkg;

  // Fraction bits of the projection parameter
  localparam int TF = 16;
  // Coordinate, offset, distance widths
  localparam int CW = 16;
  localparam int OW = CW + 1;
  localparam int DW = 25;
  // Squared length (unsigned) and dot product (signed)
  localparam int LW = 2 * OW;
  localparam int PW = 2 * OW + 1;
  // Projection parameter, error vector, its magnitude
  localparam int TW = TF + 1;
  localparam int EW = TF + 19;
  localparam int AW = TF + 18;
  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  // Squared error length and its root
  localparam int SW = 2 * AW + 1;
  localparam int RW = (SW + 1) / 2;

  // Configuration register indexes
  localparam logic [7:0] CFG_START_X = 8'd0;
  localparam logic [7:0] CFG_START_Y = 8'd1;
  localparam logic [7:0] CFG_END_X   = 8'd2;
  localparam logic [7:0] CFG_END_Y   = 8'd3;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } psd_in_t;

  typedef struct packed {
    logic [DW-1:0] distance;
    logic          degenerate;
  } psd_out_t;

  typedef struct packed {
    logic signed [OW-1:0] wx;
    logic signed [OW-1:0] wy;
    logic signed [OW-1:0] dx;
    logic signed [OW-1:0] dy;
    logic                 degen;
    logic                 sat;
  } psd_geo_t;

endpackage
`default_nettype wire

// File: sv/psd_isqrt.sv
`default_nettype none
module psd_isqrt (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic                  tag_i,
  input  wire logic [psd_pkg::SW-1:0] rad_i,
  output logic                       valid_o,
  output logic                       tag_o,
  output logic [psd_pkg::RW-1:0]     root_o
);
  import psd_pkg::*;

  localparam int XW = 2 * RW;

  logic [XW-1:0] op_q  [RW];
  logic [XW-1:0] res_q [RW];
  logic          v_q   [RW];
  logic          tag_q [RW];

  // One root bit per stage, most significant first
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [XW-1:0] op_s, res_s, one, trial;
    logic          v_s, tag_s, take;
    if (k == 0) begin : g_first
      assign op_s  = XW'(rad_i);
      assign res_s = '0;
      assign v_s   = valid_i;
      assign tag_s = tag_i;
    end else begin : g_next
      assign op_s  = op_q[k-1];
      assign res_s = res_q[k-1];
      assign v_s   = v_q[k-1];
      assign tag_s = tag_q[k-1];
    end
    assign one   = XW'(1) << (2 * (RW - 1 - k));
    assign trial = res_s + one;
    assign take  = op_s >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k] <= tag_s;
        if (take) begin
          op_q[k]  <= op_s - trial;
          res_q[k] <= (res_s >> 1) + one;
        end else begin
          op_q[k]  <= op_s;
          res_q[k] <= res_s >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign tag_o   = tag_q[RW-1];
  assign root_o  = res_q[RW-1][RW-1:0];

endmodule
`default_nettype wire

// File: sv/point_segment_distance_core.sv
`default_nettype none
// Point to segment distance, fully pipelined.
// Stages from accepted item to result: three setup stages, one clamp stage, TF divider
// stages, five error stages, TF + 19 root stages.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: rst_ni asynchronous active low clears all valid bits and the segment registers.
module point_segment_distance_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire psd_pkg::psd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output psd_pkg::psd_out_t      out_data_o
);
  import psd_pkg::*;

  logic signed [CW-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic en;

  // Segment registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_X: start_x_q <= cfg_data_i;
        CFG_START_Y: start_y_q <= cfg_data_i;
        CFG_END_X:   end_x_q   <= cfg_data_i;
        CFG_END_Y:   end_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance everything unless the result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: offsets
  logic v1_q;
  logic signed [OW-1:0] wx1_q, wy1_q, dx1_q, dy1_q;
  // Stage 2: products
  logic v2_q;
  psd_geo_t geo2_q;
  logic signed [LW-1:0] pwx2_q, pwy2_q, pdx2_q, pdy2_q;
  // Stage 3: dot and squared length
  logic v3_q;
  psd_geo_t geo3_q;
  logic signed [PW-1:0] dot3_q;
  logic [LW-1:0] len3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx1_q <= OW'(in_data_i.px) - OW'(start_x_q);
      wy1_q <= OW'(in_data_i.py) - OW'(start_y_q);
      dx1_q <= OW'(end_x_q) - OW'(start_x_q);
      dy1_q <= OW'(end_y_q) - OW'(start_y_q);

      geo2_q.wx    <= wx1_q;
      geo2_q.wy    <= wy1_q;
      geo2_q.dx    <= dx1_q;
      geo2_q.dy    <= dy1_q;
      geo2_q.degen <= 1'b0;
      geo2_q.sat   <= 1'b0;
      pwx2_q <= wx1_q * dx1_q;
      pwy2_q <= wy1_q * dy1_q;
      pdx2_q <= dx1_q * dx1_q;
      pdy2_q <= dy1_q * dy1_q;

      geo3_q <= geo2_q;
      dot3_q <= PW'(pwx2_q) + PW'(pwy2_q);
      len3_q <= LW'(pdx2_q) + LW'(pdy2_q);
    end
  end

  // Clamp and divider: stage 0 holds the clamped dividend
  logic           dv_v_q   [TF+1];
  logic [LW-1:0]  dv_rem_q [TF+1];
  logic [LW-1:0]  dv_len_q [TF+1];
  logic [TF-1:0]  dv_quo_q [TF+1];
  psd_geo_t       dv_geo_q [TF+1];

  logic len_zero, dot_pos, dot_ge;
  assign len_zero = len3_q == '0;
  assign dot_pos  = dot3_q > 0;
  assign dot_ge   = dot3_q >= $signed({1'b0, len3_q});

  // Tag the item with its special cases
  psd_geo_t geo_s;
  always_comb begin
    geo_s       = geo3_q;
    geo_s.degen = len_zero;
    geo_s.sat   = !len_zero && dot_ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_geo_q[0]       <= geo_s;
      dv_len_q[0]       <= len3_q;
      dv_quo_q[0]       <= '0;
      // zero remainder yields a zero quotient for every clamped case
      dv_rem_q[0]       <= (!len_zero && dot_pos && !dot_ge) ? dot3_q[LW-1:0] : '0;
    end
  end

  // One quotient bit per stage, restoring
  for (genvar j = 0; j < TF; j++) begin : g_div
    logic [LW:0] sh;
    logic        ge;
    assign sh = {dv_rem_q[j], 1'b0};
    assign ge = sh >= {1'b0, dv_len_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_geo_q[j+1] <= dv_geo_q[j];
        dv_len_q[j+1] <= dv_len_q[j];
        dv_quo_q[j+1] <= {dv_quo_q[j][TF-2:0], ge};
        dv_rem_q[j+1] <= ge ? LW'(sh - {1'b0, dv_len_q[j]}) : LW'(sh);
      end
    end
  end

  // Stage 5: t times direction
  logic [TW-1:0] t_s;
  assign t_s = dv_geo_q[TF].sat ? TW'(1) << TF : {1'b0, dv_quo_q[TF]};

  logic v5_q, v6_q, v7_q, v8_q, v9_q;
  logic d5_q, d6_q, d7_q, d8_q, d9_q;
  logic signed [OW-1:0] wx5_q, wy5_q;
  logic signed [EW-1:0] tdx5_q, tdy5_q;
  // Stage 6: error magnitudes
  logic [AW-1:0] ax6_q, ay6_q;
  logic signed [EW-1:0] ex_s, ey_s;
  // Stage 7: partial products
  logic [2*AH-1:0]  xhh7_q, yhh7_q;
  logic [AH+AL-1:0] xhl7_q, yhl7_q;
  logic [2*AL-1:0]  xll7_q, yll7_q;
  // Stage 8 and 9: squares and their sum
  logic [2*AW-1:0] sx8_q, sy8_q;
  logic [SW-1:0]   s9_q;

  assign ex_s = (EW'(wx5_q) <<< TF) - tdx5_q;
  assign ey_s = (EW'(wy5_q) <<< TF) - tdy5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v5_q <= dv_v_q[TF];
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d5_q   <= dv_geo_q[TF].degen;
      wx5_q  <= dv_geo_q[TF].wx;
      wy5_q  <= dv_geo_q[TF].wy;
      tdx5_q <= $signed({1'b0, t_s}) * dv_geo_q[TF].dx;
      tdy5_q <= $signed({1'b0, t_s}) * dv_geo_q[TF].dy;

      d6_q  <= d5_q;
      ax6_q <= ex_s[EW-1] ? AW'(-ex_s) : AW'(ex_s);
      ay6_q <= ey_s[EW-1] ? AW'(-ey_s) : AW'(ey_s);

      d7_q   <= d6_q;
      xhh7_q <= ax6_q[AW-1:AL] * ax6_q[AW-1:AL];
      xhl7_q <= ax6_q[AW-1:AL] * ax6_q[AL-1:0];
      xll7_q <= ax6_q[AL-1:0] * ax6_q[AL-1:0];
      yhh7_q <= ay6_q[AW-1:AL] * ay6_q[AW-1:AL];
      yhl7_q <= ay6_q[AW-1:AL] * ay6_q[AL-1:0];
      yll7_q <= ay6_q[AL-1:0] * ay6_q[AL-1:0];

      d8_q  <= d7_q;
      sx8_q <= ((2*AW)'(xhh7_q) << (2*AL)) + ((2*AW)'(xhl7_q) << (AL+1)) + (2*AW)'(xll7_q);
      sy8_q <= ((2*AW)'(yhh7_q) << (2*AL)) + ((2*AW)'(yhl7_q) << (AL+1)) + (2*AW)'(yll7_q);

      d9_q <= d8_q;
      s9_q <= SW'(sx8_q) + SW'(sy8_q);
    end
  end

  // Square root and output
  logic          sq_degen;
  logic [RW-1:0] sq_root;

  psd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .tag_i   (d9_q),
    .rad_i   (s9_q),
    .valid_o (out_valid_o),
    .tag_o   (sq_degen),
    .root_o  (sq_root)
  );

  assign out_data_o.distance   = sq_root[TF-8+DW-1:TF-8];
  assign out_data_o.degenerate = sq_degen;

  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[TF] && !dv_geo_q[TF].degen |-> dv_rem_q[TF] < dv_len_q[TF])
    else $error("divider remainder out of range");

  // Saturated items carry a zero quotient
  a_sat_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[TF] && dv_geo_q[TF].sat |-> dv_quo_q[TF] == '0)
    else $error("saturated item with nonzero quotient");

  // Zero-length segment never saturates
  a_degen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[TF] && dv_geo_q[TF].degen |-> !dv_geo_q[TF].sat)
    else $error("degenerate item flagged as clamped");

endmodule
`default_nettype wire
